/* rtl/sdtq_pkg.sv */
// shared codes, widths and helpers for the sorted deadline timer queue
// no dependencies; imported by the cell, the top level and the checker
package sdtq_pkg;

   localparam int DL_W         = 32;
   localparam int OP_W         = 2;
   localparam int KIND_W       = 2;
   localparam int RESULT_LIMIT = 16;
   localparam int RES_CNT_W    = $clog2(RESULT_LIMIT);

   // request opcodes
   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRE = 2'd2;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic            ins_go;
      logic            del_go;
      logic            pop_go;
      logic [DL_W-1:0] new_deadline;
   } cell_ctrl_type;

   // a is later than b when a - b, read as two's complement, is positive
   function automatic logic later(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
      logic [DL_W-1:0] d;
      d = a - b;
      return (d != '0) && !d[DL_W-1];
   endfunction

endpackage

/* rtl/sorted_deadline_timer_queue_unit.sv */
// Sorted deadline timer queue: holds up to MAX_TIMERS one-shot timers in a chain of cells kept
// in deadline order (wrap-aware, equal deadlines in start order). A start item (req_tuser 0)
// stores tick + delay and is acknowledged with its deadline, or with status 1 when the chain is
// full. A cancel item (req_tuser 1) removes the first timer with the tag and returns its
// deadline, or status 1 and deadline 0 when no timer has that tag. A tick item (req_tuser 2)
// advances the tick count and then emits every expired timer from the head of the chain, at
// most 16 per tick, tlast on the final one; a tick with nothing expired and opcode 3 return
// nothing. The result of a start or cancel appears the cycle after the item is taken. During
// a tick the head cell is popped once per cycle while the result register is free or being
// taken, and the chain shifts one slot per pop. req_tready is low while a tick is draining and
// while the result register is full and not being taken.
// depends on sdtq_pkg and sdtq_cell
module sorted_deadline_timer_queue_unit
   import sdtq_pkg::*;
#(
   parameter int MAX_TIMERS = 16,
   parameter int TAG_WIDTH  = 8
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // delay_ticks [31:0], timer_tag [32 +: TAG_WIDTH], zero filled to bytes
   input  logic [((DL_W+TAG_WIDTH+7)/8)*8-1:0]      req_tdata,
   // opcode
   input  logic [OP_W-1:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // result_tag [TAG_WIDTH-1:0], result_status, result_deadline, zero filled to bytes
   output logic [((TAG_WIDTH+1+DL_W+7)/8)*8-1:0]    rsp_tdata,
   // result_kind
   output logic [KIND_W-1:0]                        rsp_tuser,
   // last_in_run
   output logic                                     rsp_tlast
);

   localparam int OUT_W = ((TAG_WIDTH+1+DL_W+7)/8)*8;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_TICK = 1'b1;

   // control state
   logic                 state_ff, state_in;
   logic [DL_W-1:0]      tick_ff, tick_in;
   logic [RES_CNT_W-1:0] count_ff, count_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [TAG_WIDTH-1:0] rsp_tag_ff, rsp_tag_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [DL_W-1:0]      rsp_dl_ff, rsp_dl_in;
   logic                 rsp_last_ff, rsp_last_in;

   // request fields
   logic [DL_W-1:0]      req_delay;
   logic [TAG_WIDTH-1:0] req_tag;
   logic [DL_W-1:0]      start_dl;

   // chain wiring
   logic                 cell_valid [MAX_TIMERS];
   logic [DL_W-1:0]      cell_dl    [MAX_TIMERS];
   logic [TAG_WIDTH-1:0] cell_tag   [MAX_TIMERS];
   logic [DL_W-1:0]      cell_hit   [MAX_TIMERS];
   logic                 keep_w     [MAX_TIMERS];
   logic                 seen_w     [MAX_TIMERS];
   logic                 seen_last;
   cell_ctrl_type        ctrl;

   logic                 slot_free, accept, full;
   logic                 head_exp, next_exp;
   logic [DL_W-1:0]      cancel_dl;

   assign req_delay = req_tdata[DL_W-1:0];
   assign req_tag   = req_tdata[DL_W +: TAG_WIDTH];
   assign start_dl  = tick_ff + req_delay;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   // chain stays a prefix, so the last cell tells whether it is full
   assign full     = cell_valid[MAX_TIMERS-1];
   assign head_exp = cell_valid[0] && !later(cell_dl[0], tick_ff);
   assign next_exp = cell_valid[1] && !later(cell_dl[1], tick_ff);

   assign ctrl.ins_go       = accept && (req_tuser == OP_START) && !full;
   assign ctrl.del_go       = accept && (req_tuser == OP_CANCEL);
   assign ctrl.pop_go       = (state_ff == ST_TICK) && slot_free && head_exp;
   assign ctrl.new_deadline = start_dl;

   assign keep_w[0] = 1'b1;
   assign seen_w[0] = 1'b0;

   for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
      logic                 prev_v, next_v;
      logic [DL_W-1:0]      prev_d, next_d;
      logic [TAG_WIDTH-1:0] prev_t, next_t;
      logic                 keep_o, seen_o;

      if (i == 0) begin : g_first
         assign prev_v = 1'b0;
         assign prev_d = '0;
         assign prev_t = '0;
      end else begin : g_mid
         assign prev_v = cell_valid[i-1];
         assign prev_d = cell_dl[i-1];
         assign prev_t = cell_tag[i-1];
      end

      if (i == MAX_TIMERS-1) begin : g_last
         assign next_v    = 1'b0;
         assign next_d    = '0;
         assign next_t    = '0;
         // a tag match anywhere in the chain
         assign seen_last = seen_o;
      end else begin : g_inner
         assign next_v      = cell_valid[i+1];
         assign next_d      = cell_dl[i+1];
         assign next_t      = cell_tag[i+1];
         assign keep_w[i+1] = keep_o;
         assign seen_w[i+1] = seen_o;
      end

      sdtq_cell #(
         .TAG_WIDTH(TAG_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .new_tag       (req_tag),
         .prev_valid    (prev_v),
         .prev_deadline (prev_d),
         .prev_tag      (prev_t),
         .next_valid    (next_v),
         .next_deadline (next_d),
         .next_tag      (next_t),
         .keep_in       (keep_w[i]),
         .keep_out      (keep_o),
         .seen_in       (seen_w[i]),
         .seen_out      (seen_o),
         .valid         (cell_valid[i]),
         .deadline      (cell_dl[i]),
         .tag           (cell_tag[i]),
         .hit_deadline  (cell_hit[i])
      );
   end

   // only the first matching cell drives a nonzero deadline
   always_comb begin
      cancel_dl = '0;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         cancel_dl = cancel_dl | cell_hit[i];
      end
   end

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_dl_in     = rsp_dl_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_START: begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_START;
                     rsp_tag_in    = req_tag;
                     rsp_status_in = full;
                     rsp_dl_in     = start_dl;
                     rsp_last_in   = 1'b1;
                  end
                  OP_CANCEL: begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_CANCEL;
                     rsp_tag_in    = req_tag;
                     rsp_status_in = !seen_last;
                     rsp_dl_in     = cancel_dl;
                     rsp_last_in   = 1'b1;
                  end
                  OP_TICK: begin
                     tick_in  = tick_ff + 1'b1;
                     count_in = '0;
                     state_in = ST_TICK;
                  end
                  default: begin
                     // unused opcode: no effect
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (slot_free) begin
               if (head_exp) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_EXPIRE;
                  rsp_tag_in    = cell_tag[0];
                  rsp_status_in = 1'b0;
                  rsp_dl_in     = cell_dl[0];
                  rsp_last_in   = !next_exp || (count_ff == RES_CNT_W'(RESULT_LIMIT-1));
                  count_in      = count_ff + 1'b1;
                  if (rsp_last_in) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  // nothing expired on this tick
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dl_ff     <= rsp_dl_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = OUT_W'({rsp_dl_ff, rsp_status_ff, rsp_tag_ff});

endmodule

/* rtl/sdtq_cell.sv */
// one slot of the timer chain: valid bit, deadline and tag
// depends on sdtq_pkg; trades entries with its two neighbors
module sdtq_cell
   import sdtq_pkg::*;
#(
   parameter int TAG_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [TAG_WIDTH-1:0] new_tag,
   input  logic                 prev_valid,
   input  logic [DL_W-1:0]      prev_deadline,
   input  logic [TAG_WIDTH-1:0] prev_tag,
   input  logic                 next_valid,
   input  logic [DL_W-1:0]      next_deadline,
   input  logic [TAG_WIDTH-1:0] next_tag,
   input  logic                 keep_in,
   output logic                 keep_out,
   input  logic                 seen_in,
   output logic                 seen_out,
   output logic                 valid,
   output logic [DL_W-1:0]      deadline,
   output logic [TAG_WIDTH-1:0] tag,
   output logic [DL_W-1:0]      hit_deadline
);

   logic                 valid_ff, valid_in;
   logic [DL_W-1:0]      deadline_ff, deadline_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   logic                 match_here;

   // insert point: first cell that is empty or holds a later deadline
   assign keep_out   = keep_in && valid_ff && !later(deadline_ff, ctrl.new_deadline);
   assign match_here = valid_ff && (tag_ff == new_tag);
   assign seen_out   = seen_in || match_here;
   assign hit_deadline = (match_here && !seen_in) ? deadline_ff : '0;

   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      tag_in      = tag_ff;
      if (ctrl.ins_go && !keep_out) begin
         if (keep_in) begin
            valid_in    = 1'b1;
            deadline_in = ctrl.new_deadline;
            tag_in      = new_tag;
         end else begin
            valid_in    = prev_valid;
            deadline_in = prev_deadline;
            tag_in      = prev_tag;
         end
      end
      if ((ctrl.del_go && seen_out) || ctrl.pop_go) begin
         valid_in    = next_valid;
         deadline_in = next_deadline;
         tag_in      = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      deadline_ff <= deadline_in;
      tag_ff      <= tag_in;
   end

   assign valid    = valid_ff;
   assign deadline = deadline_ff;
   assign tag      = tag_ff;

endmodule

/* rtl/sdtq_checker.sv */
// port-level checks for the sorted deadline timer queue, bound to the top level
// depends on sdtq_pkg and sorted_deadline_timer_queue_unit
module sdtq_checker
   import sdtq_pkg::*;
#(
   parameter int TAG_WIDTH = 8
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [OP_W-1:0]                       req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((TAG_WIDTH+1+DL_W+7)/8)*8-1:0] rsp_tdata,
   input logic [KIND_W-1:0]                     rsp_tuser,
   input logic                                  rsp_tlast
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // a start is acknowledged in the next cycle
   a_start_ack: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_START)
      |=> rsp_tvalid && (rsp_tuser == KIND_START) && rsp_tlast)
      else $error("start item not acknowledged");

   // start and cancel give a single result
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_EXPIRE) |-> rsp_tlast)
      else $error("start or cancel result without tlast");

   // expiries carry ok status
   a_expire_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_EXPIRE) |-> !rsp_tdata[TAG_WIDTH])
      else $error("expiry with error status");

   // cancel miss reports deadline zero
   a_miss_dl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_CANCEL) && rsp_tdata[TAG_WIDTH]
      |-> (rsp_tdata[TAG_WIDTH+1 +: DL_W] == '0))
      else $error("cancel miss with nonzero deadline");

endmodule

bind sorted_deadline_timer_queue_unit sdtq_checker #(
   .TAG_WIDTH(TAG_WIDTH)
) u_sdtq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
